// File: src/udf_pkg.sv
`default_nettype none
package udf_pkg;

	// default geometry of the link
	localparam int STREAMS_DEF      = 4;
	localparam int GROUP_BYTES_DEF  = 28;
	localparam int CHECK_OFFSET_DEF = 24;

	// frame layout
	localparam logic [2:0] POS_LAST  = 3'd5;
	localparam logic [2:0] POS_HALF  = 3'd3;
	localparam logic [5:0] FULL_MARK = 6'h3F;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int CMD_ROW_W   = 4;

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_LENGTH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION  = 8'd1;

	// one classified byte on its way to the back end
	typedef struct packed {
		logic                 is_check;
		logic                 check_error;
		logic                 panic_flag;
		logic                 emit;
		logic [CMD_ROW_W-1:0] row;
		logic [1:0]           lane;
		logic [7:0]           value;
	} cmd_t;

	typedef enum logic {
		BK_RUN,
		BK_EMIT
	} back_state_t;

endpackage
`default_nettype wire

// File: src/udf_front.sv
`default_nettype none
module udf_front #(
	parameter int STREAMS      = udf_pkg::STREAMS_DEF,
	parameter int GROUP_BYTES  = udf_pkg::GROUP_BYTES_DEF,
	parameter int CHECK_OFFSET = udf_pkg::CHECK_OFFSET_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [udf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [udf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           byte_valid,
	input  wire logic [7:0]                     byte_value,
	input  wire logic                           q_full,
	output logic                                cfg_ready,
	output logic                                byte_stall,
	output logic                                push,
	output udf_pkg::cmd_t                       push_cmd
);
	import udf_pkg::*;

	localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int RW = $clog2(2 * STREAMS);

	logic [15:0]   tlen_q;
	logic [2:0]    start_q;
	logic [15:0]   tidx_q;
	logic [8:0]    goff_q;
	logic          par_q;
	logic [SW-1:0] stream_q;
	logic [2:0]    fpos_q;
	logic [3:0]    lane_q;
	logic [5:0]    marks_q [STREAMS];

	logic [15:0]   tidx_inc;
	logic [8:0]    goff_inc;
	logic          wrap_t;
	logic          wrap_g;
	logic          par_new;
	logic          is_check;
	logic [2:0]    chk_s;
	logic          clear_pre;
	logic [5:0]    marks_set [STREAMS];
	logic [3:0]    lane_new;
	logic          lane_done;
	logic          frame_end;
	logic          complete;
	logic          accept;
	logic          cfg_we;
	logic          hi_half;

	function automatic logic [2:0] clamp_start(input logic [2:0] p);
		return (p > POS_LAST) ? POS_LAST : p;
	endfunction

	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign byte_stall = q_full;
	assign accept     = byte_valid && !byte_stall;
	assign push       = accept && (tlen_q != 16'd0);

	always_comb begin
		tidx_inc  = tidx_q + 16'd1;
		goff_inc  = goff_q + 9'd1;
		wrap_t    = (tidx_inc == tlen_q);
		wrap_g    = (goff_inc == 9'(GROUP_BYTES));
		par_new   = wrap_t ? 1'b0 : (wrap_g ? ~par_q : par_q);
		is_check  = (goff_q >= 9'(CHECK_OFFSET)) && (goff_q < 9'(CHECK_OFFSET + STREAMS));
		chk_s     = 3'(goff_q - 9'(CHECK_OFFSET));
		clear_pre = (stream_q == '0) && (fpos_q == 3'd0);
		complete  = 1'b1;
		for (int s = 0; s < STREAMS; s++) begin
			marks_set[s] = (clear_pre ? 6'd0 : marks_q[s])
				| ((SW'(s) == stream_q) ? (6'd1 << fpos_q) : 6'd0);
			if (marks_set[s] != FULL_MARK)
				complete = 1'b0;
		end
		lane_new  = (clear_pre ? 4'd0 : lane_q) + 4'd1;
		lane_done = (lane_new == 4'(STREAMS));
		frame_end = lane_done && (fpos_q == POS_LAST);
		hi_half   = (fpos_q >= POS_HALF);

		push_cmd.is_check    = is_check;
		push_cmd.check_error = (byte_value[5:0] != {2'b00, chk_s, ~par_new});
		push_cmd.panic_flag  = byte_value[7];
		push_cmd.emit        = frame_end && complete;
		push_cmd.row         = CMD_ROW_W'(RW'({stream_q, hi_half}));
		push_cmd.lane        = hi_half ? 2'(fpos_q - POS_HALF) : 2'(fpos_q);
		push_cmd.value       = byte_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q   <= '0;
			start_q  <= '0;
			tidx_q   <= '0;
			goff_q   <= '0;
			par_q    <= 1'b0;
			stream_q <= '0;
			fpos_q   <= '0;
			lane_q   <= '0;
			for (int s = 0; s < STREAMS; s++)
				marks_q[s] <= '0;
		end else if (cfg_we && (cfg_index == CFG_TRANSFER_LENGTH ||
				cfg_index == CFG_START_POSITION)) begin
			if (cfg_index == CFG_TRANSFER_LENGTH) begin
				tlen_q <= cfg_data;
				fpos_q <= clamp_start(start_q);
			end else begin
				start_q <= cfg_data[2:0];
				fpos_q  <= clamp_start(cfg_data[2:0]);
			end
			tidx_q   <= '0;
			goff_q   <= '0;
			par_q    <= 1'b0;
			stream_q <= '0;
			lane_q   <= '0;
			for (int s = 0; s < STREAMS; s++)
				marks_q[s] <= '0;
		end else if (push) begin
			par_q <= par_new;
			if (wrap_t || wrap_g) begin
				tidx_q   <= wrap_t ? 16'd0 : tidx_inc;
				goff_q   <= '0;
				stream_q <= '0;
			end else begin
				tidx_q   <= tidx_inc;
				goff_q   <= goff_inc;
				stream_q <= (stream_q == SW'(STREAMS - 1)) ? '0 : stream_q + SW'(1);
			end
			if (!is_check) begin
				for (int s = 0; s < STREAMS; s++)
					marks_q[s] <= frame_end ? 6'd0 : marks_set[s];
				lane_q <= lane_done ? 4'd0 : lane_new;
				if (lane_done)
					fpos_q <= (fpos_q == POS_LAST) ? 3'd0 : fpos_q + 3'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/udf_queue.sv
`default_nettype none
module udf_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire udf_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output udf_pkg::cmd_t      head,
	output logic               full,
	output logic               empty
);
	import udf_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + PW'(1);
			if (pop)
				rptr_q <= rptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

// File: src/udf_back.sv
`default_nettype none
module udf_back #(
	parameter int STREAMS = udf_pkg::STREAMS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire udf_pkg::cmd_t head,
	input  wire logic          empty,
	input  wire logic          result_stall,
	output logic               pop,
	output logic               result_valid,
	output logic               kind,
	output logic               check_error,
	output logic               panic_flag,
	output logic [2:0]         channel,
	output logic signed [23:0] sample,
	output logic               last
);
	import udf_pkg::*;

	localparam int ROWS = 2 * STREAMS;
	localparam int RW   = $clog2(ROWS);

	back_state_t   state_q;
	back_state_t   state_d;
	logic [2:0][7:0] mem_q [ROWS];
	logic [2:0][7:0] rd_q;
	logic [RW-1:0] row_q;
	logic [RW-1:0] rd_addr;
	logic          rd_en;
	logic          mem_we;
	logic          load_chk;
	logic          load_smp;
	logic          out_free;
	logic          last_row;

	assign out_free = !result_valid || !result_stall;
	assign last_row = (row_q == RW'(ROWS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_RUN: begin
				if (pop && !head.is_check && head.emit)
					state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (out_free && last_row)
					state_d = BK_RUN;
			end
			default: state_d = BK_RUN;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		mem_we   = 1'b0;
		load_chk = 1'b0;
		load_smp = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		unique case (state_q)
			BK_RUN: begin
				pop      = !empty && (!head.is_check || out_free);
				load_chk = pop && head.is_check;
				mem_we   = pop && !head.is_check;
				rd_en    = mem_we && head.emit;
			end
			BK_EMIT: begin
				load_smp = out_free;
				rd_en    = out_free && !last_row;
				rd_addr  = row_q + RW'(1);
			end
			default: ;
		endcase
	end

	// pending store: one row per stream half, three byte lanes
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[head.row[RW-1:0]][head.lane] <= head.value;
		if (rd_en)
			rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (load_chk) begin
			kind        <= 1'b0;
			check_error <= head.check_error;
			panic_flag  <= head.panic_flag;
			channel     <= 3'd0;
			sample      <= '0;
			last        <= 1'b0;
		end else if (load_smp) begin
			kind        <= 1'b1;
			check_error <= 1'b0;
			panic_flag  <= 1'b0;
			channel     <= 3'(row_q);
			sample      <= $signed({rd_q[0], rd_q[1], rd_q[2]});
			last        <= last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_RUN;
			row_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rd_en)
				row_q <= rd_addr;
			if (load_chk || load_smp)
				result_valid <= 1'b1;
			else if (!result_stall)
				result_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: src/audio_usb_frame_deframer_top.sv
// USB frame deframer for a multi-stream 24-bit audio link. Each request on the byte
// channel carries one raw USB byte. The front end counts the byte's place in the
// transfer (transfer_length bytes) and in a group of GROUP_BYTES bytes, classifies it
// as a check byte (group offsets CHECK_OFFSET .. CHECK_OFFSET+STREAMS-1) or a sample
// byte, tracks presence marks per stream and decides frame completeness; it takes one
// byte per cycle as long as the four-entry command queue has room. The back end
// retires one queued command per cycle while no frame goes out and, for a check
// byte, while the result output is free: a check byte gives one verdict request, a
// sample byte is written into the pending store (one row per stream half, three
// byte lanes). When position 5 closes with every mark set, the back end reads the
// store through its single read port, one row per cycle while results are not
// stalled, and sends 2*STREAMS sample requests, the last one flagged; the queue
// fills and stalls the byte channel while a frame goes out. Result stalls hold the
// back end. A transfer length of 0 swallows bytes. Writing either register restarts
// the counters and marks (the pending store keeps its data); registers are to be
// written only while the block is idle; not enforced. There is no clearing pass.
`default_nettype none
module audio_usb_frame_deframer_top #(
	parameter int STREAMS      = udf_pkg::STREAMS_DEF,
	parameter int GROUP_BYTES  = udf_pkg::GROUP_BYTES_DEF,
	parameter int CHECK_OFFSET = udf_pkg::CHECK_OFFSET_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration writes
	input  wire logic                           cfg_valid,
	input  wire logic [udf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [udf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                cfg_ready,
	// byte channel
	input  wire logic                           byte_valid,
	input  wire logic [7:0]                     byte_value,
	output logic                                byte_stall,
	// result channel
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output logic                                kind,
	output logic                                check_error,
	output logic                                panic_flag,
	output logic [2:0]                          channel,
	output logic signed [23:0]                  sample,
	output logic                                last
);
	import udf_pkg::*;

	// front to queue
	logic q_push;
	cmd_t q_push_cmd;
	logic q_full;

	// queue to back
	cmd_t q_head;
	logic q_empty;
	logic q_pop;

	// counters, classification and frame bookkeeping
	udf_front #(
		.STREAMS      (STREAMS),
		.GROUP_BYTES  (GROUP_BYTES),
		.CHECK_OFFSET (CHECK_OFFSET)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_valid (byte_valid),
		.byte_value (byte_value),
		.q_full     (q_full),
		.cfg_ready  (cfg_ready),
		.byte_stall (byte_stall),
		.push       (q_push),
		.push_cmd   (q_push_cmd)
	);

	// decouples byte intake from store writes and frame emission
	udf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// pending store, frame readout and output register
	udf_back #(
		.STREAMS (STREAMS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.empty        (q_empty),
		.result_stall (result_stall),
		.pop          (q_pop),
		.result_valid (result_valid),
		.kind         (kind),
		.check_error  (check_error),
		.panic_flag   (panic_flag),
		.channel      (channel),
		.sample       (sample),
		.last         (last)
	);

endmodule
`default_nettype wire

// File: bench/deframer_frame_checker.sv
module deframer_frame_checker #(
	parameter int STREAMS      = udf_pkg::STREAMS_DEF,
	parameter int GROUP_BYTES  = udf_pkg::GROUP_BYTES_DEF,
	parameter int CHECK_OFFSET = udf_pkg::CHECK_OFFSET_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [udf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [udf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           byte_valid,
	input  wire logic                           byte_stall,
	input  wire logic [7:0]                     byte_value,
	input  wire logic                           result_valid,
	input  wire logic                           result_stall,
	input  wire logic                           kind,
	input  wire logic                           check_error,
	input  wire logic                           panic_flag,
	input  wire logic [2:0]                     channel,
	input  wire logic [23:0]                    sample,
	input  wire logic                           last,
	output int                                  fail_count,
	output int                                  outstanding,
	output int                                  verdict_count,
	output int                                  sample_count,
	output int                                  frame_count
);

	localparam int POSITIONS = 6;

	typedef struct packed {
		logic        kind;
		logic        check_error;
		logic        panic_flag;
		logic [2:0]  channel;
		logic [23:0] sample;
		logic        last;
	} deframe_out_t;

	deframe_out_t due_results[$];

	// predicted block state
	logic [15:0] xfer_len;
	logic [2:0]  first_pos;
	logic [7:0]  held_bytes [STREAMS][POSITIONS];
	logic [5:0]  marks [STREAMS];
	logic [3:0]  lanes;
	logic [2:0]  fpos;
	logic [15:0] xfer_idx;
	logic [8:0]  grp_off;
	logic        grp_par;

	task automatic restart_decode();
		for (int s = 0; s < STREAMS; s++)
			marks[s] = '0;
		lanes    = '0;
		fpos     = (first_pos > udf_pkg::POS_LAST) ? udf_pkg::POS_LAST : first_pos;
		xfer_idx = '0;
		grp_off  = '0;
		grp_par  = 1'b0;
	endtask

	task automatic decode_byte(input logic [7:0] value);
		logic [8:0]   off;
		int           lane;
		logic         whole;
		deframe_out_t r;
		if (xfer_len == '0)
			return;
		off      = grp_off;
		xfer_idx = xfer_idx + 16'd1;
		grp_off  = grp_off + 9'd1;
		if (xfer_idx == xfer_len) begin
			xfer_idx = '0;
			grp_off  = '0;
			grp_par  = 1'b0;
		end else if (grp_off == 9'(GROUP_BYTES)) begin
			grp_off = '0;
			grp_par = ~grp_par;
		end

		// check byte: verdict only
		if (off >= 9'(CHECK_OFFSET) && off < 9'(CHECK_OFFSET + STREAMS)) begin
			lane          = int'(off) - CHECK_OFFSET;
			r             = '0;
			r.check_error = ({2'b00, value[5:0]} != 8'((lane << 1) | (grp_par ? 0 : 1)));
			r.panic_flag  = value[7];
			due_results.push_back(r);
			return;
		end

		lane = int'(off) % STREAMS;
		if (fpos > udf_pkg::POS_LAST)
			fpos = udf_pkg::POS_LAST;
		if (lane == 0 && fpos == 3'd0) begin
			for (int s = 0; s < STREAMS; s++)
				marks[s] = '0;
			lanes = '0;
		end
		held_bytes[lane][fpos] = value;
		marks[lane][fpos]      = 1'b1;
		lanes                  = lanes + 4'd1;

		if (lanes == 4'(STREAMS)) begin
			if (fpos == udf_pkg::POS_LAST) begin
				whole = 1'b1;
				for (int s = 0; s < STREAMS; s++)
					if (marks[s] != udf_pkg::FULL_MARK)
						whole = 1'b0;
				if (whole) begin
					for (int s = 0; s < STREAMS; s++) begin
						r         = '0;
						r.kind    = 1'b1;
						r.channel = 3'(s * 2);
						r.sample  = {held_bytes[s][0], held_bytes[s][1], held_bytes[s][2]};
						due_results.push_back(r);
						r.channel = 3'(s * 2 + 1);
						r.sample  = {held_bytes[s][3], held_bytes[s][4], held_bytes[s][5]};
						r.last    = (s == STREAMS - 1);
						due_results.push_back(r);
					end
				end
				for (int s = 0; s < STREAMS; s++)
					marks[s] = '0;
			end
			fpos  = (fpos == udf_pkg::POS_LAST) ? 3'd0 : fpos + 3'd1;
			lanes = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		deframe_out_t want;
		if (!arst_n) begin
			xfer_len  = '0;
			first_pos = '0;
			for (int s = 0; s < STREAMS; s++)
				for (int p = 0; p < POSITIONS; p++)
					held_bytes[s][p] = '0;
			restart_decode();
			due_results.delete();
			fail_count    = 0;
			outstanding   = 0;
			verdict_count = 0;
			sample_count  = 0;
			frame_count   = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t: result with nothing expected: kind %0d channel %0d sample %0h",
						$time, kind, channel, sample);
				end else begin
					want = due_results.pop_front();
					check_field("kind", 24'(want.kind), 24'(kind));
					check_field("check_error", 24'(want.check_error), 24'(check_error));
					check_field("panic_flag", 24'(want.panic_flag), 24'(panic_flag));
					check_field("channel", 24'(want.channel), 24'(channel));
					check_field("sample", want.sample, sample);
					check_field("last", 24'(want.last), 24'(last));
					if (want.kind)
						sample_count++;
					else
						verdict_count++;
					if (want.last)
						frame_count++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == udf_pkg::CFG_TRANSFER_LENGTH) begin
					xfer_len = cfg_data;
					restart_decode();
				end else if (cfg_index == udf_pkg::CFG_START_POSITION) begin
					first_pos = cfg_data[2:0];
					restart_decode();
				end
			end
			if (byte_valid && !byte_stall)
				decode_byte(byte_value);
			outstanding = due_results.size();
		end
	end

endmodule

// File: bench/audio_usb_frame_deframer_top_tb.sv
module audio_usb_frame_deframer_top_tb;

	localparam int STREAMS      = udf_pkg::STREAMS_DEF;
	localparam int GROUP_BYTES  = udf_pkg::GROUP_BYTES_DEF;
	localparam int CHECK_OFFSET = udf_pkg::CHECK_OFFSET_DEF;

	localparam int HALF_PERIOD  = 4;
	localparam int RANDOM_ITEMS = 410;
	// queue of four commands plus a frame of 2*STREAMS reads, with margin
	localparam int DRAIN_CYCLES = 24;
	localparam int IDLE_LIMIT   = 4000;
	localparam int IDLE_PERCENT = 9;

	// how the bytes of a phase are made
	typedef enum logic [1:0] {
		FLOW_CLEAN,   // random samples, check bytes mostly correct
		FLOW_NOISE,   // every byte random
		FLOW_EXTREME  // samples cycle through the extreme byte values
	} flow_t;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           cfg_valid    = 1'b0;
	logic [udf_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [udf_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
	logic                           cfg_ready;
	logic                           byte_valid   = 1'b0;
	logic [7:0]                     byte_value   = '0;
	logic                           byte_stall;
	logic                           result_valid;
	logic                           result_stall = 1'b0;
	logic                           kind;
	logic                           check_error;
	logic                           panic_flag;
	logic [2:0]                     channel;
	logic signed [23:0]             sample;
	logic                           last;

	// no idling on either side while calm is set
	logic calm = 1'b0;

	int fail_count;
	int outstanding;
	int verdict_count;
	int sample_count;
	int frame_count;

	int idle_cycles  = 0;
	int bytes_sent   = 0;
	int random_items = 0;
	int phases       = 0;

	// our own view of the byte counters, only to build well-formed check bytes
	logic [15:0] cur_len = '0;
	logic [15:0] at_idx  = '0;
	logic [8:0]  at_off  = '0;
	logic        at_par  = 1'b0;

	audio_usb_frame_deframer_top #(
		.STREAMS      (STREAMS),
		.GROUP_BYTES  (GROUP_BYTES),
		.CHECK_OFFSET (CHECK_OFFSET)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg_ready    (cfg_ready),
		.byte_valid   (byte_valid),
		.byte_value   (byte_value),
		.byte_stall   (byte_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.check_error  (check_error),
		.panic_flag   (panic_flag),
		.channel      (channel),
		.sample       (sample),
		.last         (last)
	);

	deframer_frame_checker #(
		.STREAMS      (STREAMS),
		.GROUP_BYTES  (GROUP_BYTES),
		.CHECK_OFFSET (CHECK_OFFSET)
	) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.byte_value    (byte_value),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.check_error   (check_error),
		.panic_flag    (panic_flag),
		.channel       (channel),
		.sample        (sample),
		.last          (last),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.verdict_count (verdict_count),
		.sample_count  (sample_count),
		.frame_count   (frame_count)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// receiver stalls at random, changed at the falling edge only
	always @(negedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	// watchdog: any request moving on any channel restarts the count
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request moved for %0d cycles, %0d results still due",
				$time, idle_cycles, outstanding);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one register write; cfg_valid stays high for a following write
	task automatic cfg_write(input logic [udf_pkg::CFG_IDX_W-1:0] idx,
			input logic [udf_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// drop the byte request, let every due result arrive, then let
	// sample bytes still queued inside the block retire
	task automatic wait_quiet();
		byte_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// new settings while idle; a stray write to an unused index goes first when asked
	task automatic apply_settings(input logic [15:0] len,
			input logic [udf_pkg::CFG_DATA_W-1:0] pos_word, input logic stray);
		wait_quiet();
		if (stray)
			cfg_write(8'($urandom_range(2, 255)), 16'($urandom));
		if ($urandom_range(0, 1) == 0) begin
			cfg_write(udf_pkg::CFG_START_POSITION, pos_word);
			cfg_write(udf_pkg::CFG_TRANSFER_LENGTH, len);
		end else begin
			cfg_write(udf_pkg::CFG_TRANSFER_LENGTH, len);
			cfg_write(udf_pkg::CFG_START_POSITION, pos_word);
		end
		cfg_valid <= 1'b0;
		// a write to either register restarts the counters
		cur_len = len;
		at_idx  = '0;
		at_off  = '0;
		at_par  = 1'b0;
		phases++;
	endtask

	// send count bytes, shaped by flow
	task automatic run_phase(input int count, input flow_t flow);
		logic [7:0] v;
		logic       par_after;
		int         lane;
		for (int n = 0; n < count; n++) begin
			v = 8'($urandom);
			if (flow == FLOW_EXTREME) begin
				case (n % 4)
					0: v = 8'h00;
					1: v = 8'hFF;
					2: v = 8'h80;
					default: v = 8'h7F;
				endcase
			end

			// check byte: pattern uses the parity after this byte is counted
			if (flow != FLOW_NOISE && cur_len != '0 && at_off >= 9'(CHECK_OFFSET) &&
					at_off < 9'(CHECK_OFFSET + STREAMS)) begin
				lane      = int'(at_off) - CHECK_OFFSET;
				par_after = at_par;
				if (at_idx + 16'd1 == cur_len)
					par_after = 1'b0;
				else if (at_off + 9'd1 == 9'(GROUP_BYTES))
					par_after = ~at_par;
				v[5:0] = 6'((lane << 1) | (par_after ? 0 : 1));
				v[6]   = 1'($urandom);
				v[7]   = ($urandom_range(0, 99) < 10);
				if (flow == FLOW_EXTREME) begin
					// first check byte: panic and a wrong pattern at once
					v = (lane == 0) ? 8'hFF : {2'b01, v[5:0]};
				end else if ($urandom_range(0, 99) < 8) begin
					v[5:0] = v[5:0] ^ 6'(1 << $urandom_range(0, 5));
				end
			end

			// sender gaps
			while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
				byte_valid <= 1'b0;
				@(negedge clk);
			end
			byte_valid <= 1'b1;
			byte_value <= v;
			@(posedge clk);
			while (byte_stall) @(posedge clk);
			@(negedge clk);
			bytes_sent++;

			// follow the block's transfer and group counting
			if (cur_len != '0) begin
				at_idx = at_idx + 16'd1;
				at_off = at_off + 9'd1;
				if (at_idx == cur_len) begin
					at_idx = '0;
					at_off = '0;
					at_par = 1'b0;
				end else if (at_off == 9'(GROUP_BYTES)) begin
					at_off = '0;
					at_par = ~at_par;
				end
			end
		end
	endtask

	initial begin : stimulus
		int          pick;
		int          count;
		logic [15:0] len;
		logic [2:0]  pos;
		flow_t       flow;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero transfer length swallows the extreme bytes
		run_phase(2, FLOW_EXTREME);

		// directed: start position above five, a stray unused index, and a transfer
		// that ends on the first check byte so the counters wrap right after it
		apply_settings(16'd25, 16'hFFFF, 1'b1);
		run_phase(25, FLOW_EXTREME);

		// random phases, each under fresh settings
		while (random_items < RANDOM_ITEMS) begin
			// a long stretch without any idling in the middle of the run
			calm <= (phases >= 4 && phases < 7);
			pick  = $urandom_range(0, 99);
			pos   = 3'($urandom_range(0, 5));
			count = $urandom_range(24, 80);
			if (pick < 55) begin
				// whole groups per transfer keep the frames aligned
				len = 16'(GROUP_BYTES * $urandom_range(1, 3));
			end else if (pick < 65) begin
				len = 16'hFFFF;
				pos = 3'($urandom_range(0, 7));
			end else if (pick < 80) begin
				len = 16'($urandom_range(1, 120));
				pos = 3'($urandom_range(0, 7));
			end else if (pick < 88) begin
				len   = 16'd0;
				count = $urandom_range(4, 12);
			end else begin
				len = 16'($urandom);
				pos = 3'($urandom_range(0, 7));
			end
			flow = ($urandom_range(0, 99) < 78) ? FLOW_CLEAN : FLOW_NOISE;
			apply_settings(len, {13'($urandom), pos}, $urandom_range(0, 9) == 0);
			run_phase(count, flow);
			if (len != '0)
				random_items += count;
		end

		// drain: all results in, then the block's own latency
		wait_quiet();

		$display("sent %0d bytes under %0d register settings", bytes_sent, phases);
		$display("checked %0d check verdicts and %0d samples in %0d frames",
			verdict_count, sample_count, frame_count);
		if (fail_count == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results never arrived", fail_count, outstanding);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
